>>> rtl/icmp_echo_request_reply_engine_unit_macros.svh
// Assertion macros shared by the echo engine RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ICMP_ECHO_REQUEST_REPLY_ENGINE_UNIT_MACROS_SVH
`define ICMP_ECHO_REQUEST_REPLY_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge except while reset is high.
`define ICMP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ICMP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ICMP_ASSERT(label, clk, rst, prop, msg)
`define ICMP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/icmp_echo_pkg.sv
`timescale 1ns / 1ps

package icmp_echo_pkg;

   localparam int PAYLOAD_BYTES_DEF = 32;
   localparam int MAX_PACKET_DEF    = 4096;

   // Byte counter width and its hard ceiling.
   localparam int POS_W     = 13;
   localparam int POS_LIMIT = 8191;

   localparam int IP_HDR_BYTES   = 20;
   localparam int ECHO_HDR_BYTES = 8;

   localparam logic [7:0]  TYPE_V4_REPLY  = 8'd0;
   localparam logic [7:0]  TYPE_V4_ERROR  = 8'd3;
   localparam logic [7:0]  TYPE_V6_REPLY  = 8'd129;
   localparam logic [7:0]  TYPE_V6_ERROR  = 8'd1;
   localparam logic [15:0] CSUM_TYPE_WORD = 16'h0800;
   localparam logic [15:0] SEQ_MAX        = 16'hFFFF;
   localparam logic [15:0] SEQ_RESET      = 16'd1;
   localparam logic [7:0]  FILL_RESET     = 8'h45;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IPV6_MODE  = 2'd0,
      CSR_IDENTIFIER = 2'd1,
      CSR_FILL_BYTE  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_SEND   = 2'd0,
      FUNC_BYTE   = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_CANCEL = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_DONE        = 3'd0,
      ST_SUCCESS     = 3'd1,
      ST_IGNORED     = 3'd2,
      ST_ERROR_REPLY = 3'd3,
      ST_BAD_COUNT   = 3'd4,
      ST_NOT_WAITING = 3'd5
   } status_type;

   // Parser control from the top level.
   typedef struct packed {
      logic byte_en;  // a reply byte is processed this cycle
      logic clear;    // return the parser to byte zero after this cycle
   } parse_ctrl_type;

endpackage

>>> rtl/icmp_echo_parse.sv
`timescale 1ns / 1ps

`include "icmp_echo_request_reply_engine_unit_macros.svh"

module icmp_echo_parse #(
   parameter int PAYLOAD_BYTES = icmp_echo_pkg::PAYLOAD_BYTES_DEF,
   parameter int MAX_PACKET    = icmp_echo_pkg::MAX_PACKET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  icmp_echo_pkg::parse_ctrl_type ctrl,
   input  logic [7:0]                   data_byte,
   input  logic                         ipv6_mode,
   input  logic [7:0]                   fill_byte,
   input  logic [15:0]                  identifier,
   input  logic [15:0]                  seq_number,
   output icmp_echo_pkg::status_type    verdict
);

   localparam int PW = icmp_echo_pkg::POS_W;
   localparam logic [PW-1:0] PosCap = PW'(MAX_PACKET < icmp_echo_pkg::POS_LIMIT ?
                                          MAX_PACKET : icmp_echo_pkg::POS_LIMIT);
   localparam logic [PW-1:0] PayLen = PW'(PAYLOAD_BYTES);
   localparam logic [PW:0]   PayEnd = (PW+1)'(PAYLOAD_BYTES + icmp_echo_pkg::ECHO_HDR_BYTES);
   localparam logic [PW-1:0] EchoHdr = PW'(icmp_echo_pkg::ECHO_HDR_BYTES);

   logic [PW-1:0] pos_ff, pos_in, pos_parsed;
   logic [7:0]    type_ff, type_in, type_parsed;
   logic [15:0]   ident_ff, ident_in, ident_parsed;
   logic [15:0]   seq_ff, seq_in, seq_parsed;
   logic          mismatch_ff, mismatch_in, mismatch_parsed;

   logic [PW-1:0] hdr;
   logic [PW-1:0] rel;
   logic [PW-1:0] min_len;
   logic [7:0]    good_type;
   logic [7:0]    err_type;

   assign hdr       = ipv6_mode ? '0 : PW'(icmp_echo_pkg::IP_HDR_BYTES);
   assign rel       = pos_ff - hdr;
   assign min_len   = hdr + EchoHdr;
   assign good_type = ipv6_mode ? icmp_echo_pkg::TYPE_V6_REPLY : icmp_echo_pkg::TYPE_V4_REPLY;
   assign err_type  = ipv6_mode ? icmp_echo_pkg::TYPE_V6_ERROR : icmp_echo_pkg::TYPE_V4_ERROR;

   // Field capture for the current byte; the verdict looks at these values.
   always_comb begin
      pos_parsed      = pos_ff;
      type_parsed     = type_ff;
      ident_parsed    = ident_ff;
      seq_parsed      = seq_ff;
      mismatch_parsed = mismatch_ff;
      if (pos_ff < PosCap) begin
         if (pos_ff >= hdr) begin
            case (rel)
               PW'(0): type_parsed = data_byte;
               PW'(4), PW'(5): ident_parsed = {ident_ff[7:0], data_byte};
               PW'(6), PW'(7): seq_parsed = {seq_ff[7:0], data_byte};
               default: begin
                  if (rel >= EchoHdr && {1'b0, rel} < PayEnd && data_byte != fill_byte) begin
                     mismatch_parsed = 1'b1;
                  end
               end
            endcase
         end
         pos_parsed = pos_ff + PW'(1);
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      type_in     = type_ff;
      ident_in    = ident_ff;
      seq_in      = seq_ff;
      mismatch_in = mismatch_ff;
      if (ctrl.clear) begin
         pos_in      = '0;
         type_in     = '0;
         ident_in    = '0;
         seq_in      = '0;
         mismatch_in = 1'b0;
      end else if (ctrl.byte_en) begin
         pos_in      = pos_parsed;
         type_in     = type_parsed;
         ident_in    = ident_parsed;
         seq_in      = seq_parsed;
         mismatch_in = mismatch_parsed;
      end
   end

   always_comb begin
      if (pos_parsed < min_len) begin
         verdict = icmp_echo_pkg::ST_IGNORED;
      end else if (type_parsed != good_type) begin
         verdict = (type_parsed == err_type) ? icmp_echo_pkg::ST_ERROR_REPLY
                                             : icmp_echo_pkg::ST_IGNORED;
      end else if (ident_parsed != identifier || seq_parsed != seq_number) begin
         verdict = icmp_echo_pkg::ST_IGNORED;
      end else if (pos_parsed - min_len != PayLen) begin
         verdict = icmp_echo_pkg::ST_BAD_COUNT;
      end else if (mismatch_parsed) begin
         verdict = icmp_echo_pkg::ST_IGNORED;
      end else begin
         verdict = icmp_echo_pkg::ST_SUCCESS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         type_ff     <= '0;
         ident_ff    <= '0;
         seq_ff      <= '0;
         mismatch_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         type_ff     <= type_in;
         ident_ff    <= ident_in;
         seq_ff      <= seq_in;
         mismatch_ff <= mismatch_in;
      end
   end

   `ICMP_ASSERT(a_pos_capped, clock, reset, pos_ff <= PosCap, "byte count ran past its cap")
   `ICMP_ASSERT(a_clear_zeroes, clock, reset, $past(ctrl.clear) |-> pos_ff == '0 && !mismatch_ff, "parser not cleared")
   `ICMP_ASSERT(a_short_ignored, clock, reset, pos_parsed < min_len |-> verdict == icmp_echo_pkg::ST_IGNORED, "short reply not ignored")

endmodule

>>> rtl/icmp_echo_request_reply_engine_unit.sv
`timescale 1ns / 1ps

// Channel  | Ports                                   | Direction
// request  | req_valid/req_ready, req_* fields       | in
// response | rsp_valid/rsp_ready, rsp_* fields       | out
// control  | csr_write_en, csr_index, csr_write_data | in
//
// Each word passes through the input register before it reaches the result register,
// and one word is taken per cycle while the response is not stalled.
// The parser and round-trip counter update in the cycle a word leaves the input register.
// A stalled response holds the input register; req_ready stays high while that
// register is empty or moving on. Ticks and non-final reply bytes give no response.
// Reset is synchronous and puts the engine idle with sequence number one.

`include "icmp_echo_request_reply_engine_unit_macros.svh"

module icmp_echo_request_reply_engine_unit #(
   parameter int PAYLOAD_BYTES = icmp_echo_pkg::PAYLOAD_BYTES_DEF,
   parameter int MAX_PACKET    = icmp_echo_pkg::MAX_PACKET_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last,
   input  logic                                 req_reset_stamp,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [15:0]                          rsp_sequence_res,
   output logic [15:0]                          rsp_checksum,
   output logic [31:0]                          rsp_round_trip_ticks,
   output logic                                 rsp_waiting,
   input  logic                                 csr_write_en,
   input  logic [icmp_echo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [icmp_echo_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int  PayHalf = PAYLOAD_BYTES / 2;
   localparam bit  PayOdd  = (PAYLOAD_BYTES % 2) != 0;

   // Configuration.
   logic        ipv6_mode_ff;
   logic [15:0] identifier_ff;
   logic [7:0]  fill_byte_ff;

   // Input register.
   logic        in_valid_ff;
   logic [1:0]  in_func_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        in_stamp_ff;

   // Engine state.
   logic        wait_ff, wait_in;
   logic [15:0] seq_ff, seq_in, seq_next;
   logic [31:0] elapsed_ff, elapsed_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [15:0] rsp_seq_ff;
   logic [15:0] rsp_csum_ff;
   logic [31:0] rsp_rtt_ff;
   logic        rsp_wait_ff;

   logic                      advance;
   logic                      res_valid;
   icmp_echo_pkg::status_type res_status;
   logic [15:0]               res_csum;
   logic [31:0]               res_rtt;
   icmp_echo_pkg::parse_ctrl_type parse_ctrl;
   icmp_echo_pkg::status_type verdict;

   logic [25:0] csum_sum;
   logic [16:0] csum_fold1;
   logic [16:0] csum_fold2;
   logic [15:0] csum_fold3;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign parse_ctrl.byte_en = advance && in_func_ff == icmp_echo_pkg::FUNC_BYTE;
   assign parse_ctrl.clear   = advance && (in_func_ff == icmp_echo_pkg::FUNC_SEND ||
                                (in_func_ff == icmp_echo_pkg::FUNC_BYTE && in_last_ff));

   assign seq_next = (seq_ff == icmp_echo_pkg::SEQ_MAX) ? 16'd1 : seq_ff + 16'd1;

   icmp_echo_parse #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .MAX_PACKET   (MAX_PACKET)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (parse_ctrl),
      .data_byte (in_byte_ff),
      .ipv6_mode (ipv6_mode_ff),
      .fill_byte (fill_byte_ff),
      .identifier(identifier_ff),
      .seq_number(seq_ff),
      .verdict   (verdict)
   );

   // Request checksum over the type word, identifier, new sequence and the fill
   // bytes, folded back to sixteen bits with end-around carries.
   always_comb begin
      csum_sum = 26'(icmp_echo_pkg::CSUM_TYPE_WORD) + 26'(identifier_ff) + 26'(seq_next)
               + 26'(PayHalf) * 26'({fill_byte_ff, fill_byte_ff})
               + (PayOdd ? 26'({fill_byte_ff, 8'h00}) : 26'd0);
      csum_fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[25:16]);
      csum_fold2 = 17'(csum_fold1[15:0]) + 17'(csum_fold1[16]);
      csum_fold3 = csum_fold2[15:0] + 16'(csum_fold2[16]);
   end

   always_comb begin
      wait_in    = wait_ff;
      seq_in     = seq_ff;
      elapsed_in = elapsed_ff;
      res_valid  = 1'b0;
      res_status = icmp_echo_pkg::ST_DONE;
      res_csum   = '0;
      res_rtt    = '0;
      case (in_func_ff)
         icmp_echo_pkg::FUNC_SEND: begin
            seq_in     = seq_next;
            wait_in    = 1'b1;
            elapsed_in = '0;
            res_valid  = 1'b1;
            res_csum   = ipv6_mode_ff ? 16'd0 : ~csum_fold3;
         end
         icmp_echo_pkg::FUNC_BYTE: begin
            if (in_last_ff) begin
               res_valid = 1'b1;
               if (!wait_ff) begin
                  res_status = icmp_echo_pkg::ST_NOT_WAITING;
               end else begin
                  res_status = verdict;
                  if (verdict == icmp_echo_pkg::ST_SUCCESS) begin
                     res_rtt    = elapsed_ff;
                     wait_in    = 1'b0;
                     elapsed_in = '0;
                  end
               end
            end
         end
         icmp_echo_pkg::FUNC_TICK: begin
            if (elapsed_ff != '1) begin
               elapsed_in = elapsed_ff + 32'd1;
            end
         end
         icmp_echo_pkg::FUNC_CANCEL: begin
            res_valid = 1'b1;
            if (wait_ff) begin
               wait_in = 1'b0;
               if (in_stamp_ff) begin
                  elapsed_in = '0;
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv6_mode_ff  <= 1'b0;
         identifier_ff <= '0;
         fill_byte_ff  <= icmp_echo_pkg::FILL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            icmp_echo_pkg::CSR_IPV6_MODE:  ipv6_mode_ff  <= csr_write_data[0];
            icmp_echo_pkg::CSR_IDENTIFIER: identifier_ff <= csr_write_data[15:0];
            icmp_echo_pkg::CSR_FILL_BYTE:  fill_byte_ff  <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         wait_ff      <= 1'b0;
         seq_ff       <= icmp_echo_pkg::SEQ_RESET;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            wait_ff    <= wait_in;
            seq_ff     <= seq_in;
            elapsed_ff <= elapsed_in;
         end
         if (advance && res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff  <= req_func;
         in_byte_ff  <= req_data_byte;
         in_last_ff  <= req_last;
         in_stamp_ff <= req_reset_stamp;
      end
      if (advance && res_valid) begin
         rsp_status_ff <= res_status;
         rsp_seq_ff    <= seq_in;
         rsp_csum_ff   <= res_csum;
         rsp_rtt_ff    <= res_rtt;
         rsp_wait_ff   <= wait_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_sequence_res     = rsp_seq_ff;
   assign rsp_checksum         = rsp_csum_ff;
   assign rsp_round_trip_ticks = rsp_rtt_ff;
   assign rsp_waiting          = rsp_wait_ff;

   `ICMP_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset |-> !wait_ff && !rsp_valid_ff, "engine not idle after reset")
   `ICMP_ASSERT(a_seq_nonzero, clock, reset, seq_ff != 16'd0, "sequence number reached zero")
   `ICMP_ASSERT(a_success_clears_wait, clock, reset, rsp_valid_ff && rsp_status_ff == icmp_echo_pkg::ST_SUCCESS |-> !rsp_wait_ff, "wait flag kept after success")
   `ICMP_ASSERT(a_rtt_only_success, clock, reset, rsp_valid_ff && rsp_status_ff != icmp_echo_pkg::ST_SUCCESS |-> rsp_rtt_ff == 32'd0, "round trip reported without success")
   `ICMP_ASSERT(a_wait_fall_cause, clock, reset, $fell(wait_ff) |-> $past(advance) && ($past(in_func_ff) == icmp_echo_pkg::FUNC_BYTE || $past(in_func_ff) == icmp_echo_pkg::FUNC_CANCEL), "wait flag dropped without reply or cancel")

endmodule
